/* sv/scd_pkg.sv */
`timescale 1ns / 1ps

package scd_pkg;

    localparam int MAG_W      = 33;               // |b - a| per axis
    localparam int S2_W       = 34;               // doubled sum of interaction radii
    localparam int DIST2_W    = 68;               // squared centre distance
    localparam int DIST_W     = 35;               // integer square root of DIST2_W
    localparam int SQRT_STEPS = DIST_W;           // one root bit per stage
    localparam int NUM_W      = 64;               // normal dividend
    localparam int QUO_W      = 31;               // normal quotient, at most 2^30
    localparam int DIV_STEPS  = QUO_W;            // one quotient bit per stage
    localparam int K2_W       = 37;               // b_radius - a_radius + distance
    localparam int KMAG_W     = K2_W - 1;
    localparam int KHALF_W    = KMAG_W / 2;
    localparam int PP_W       = KHALF_W + QUO_W;  // partial product width
    localparam int PSUM_W     = KMAG_W + QUO_W;   // full offset product width
    localparam int OFFM_W     = PSUM_W - 31;      // offset magnitude after q31 shift
    localparam int WIDE_W     = 38;               // pre-saturation coordinate width

    localparam logic [QUO_W-1:0]  NORM_ONE   = QUO_W'(32'h4000_0000);
    localparam logic [PSUM_W-1:0] ROUND_HALF = PSUM_W'(32'h4000_0000);

    typedef struct packed {
        logic signed [31:0] a_pos_x;
        logic signed [31:0] a_pos_y;
        logic signed [31:0] a_pos_z;
        logic signed [31:0] b_pos_x;
        logic signed [31:0] b_pos_y;
        logic signed [31:0] b_pos_z;
        logic [30:0]        a_radius;
        logic [30:0]        b_radius;
        logic [30:0]        a_reach;
        logic [30:0]        b_reach;
    } in_item_t;

    typedef struct packed {
        logic               in_contact;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic [31:0]        gap_distance;
        logic signed [31:0] overlap;
        logic signed [31:0] touch_x;
        logic signed [31:0] touch_y;
        logic signed [31:0] touch_z;
    } out_item_t;

    function automatic logic [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic [31:0] r;
        if (v > $signed(WIDE_W'(32'h7FFF_FFFF)))
            r = 32'h7FFF_FFFF;
        else if (v < -$signed(WIDE_W'(33'h0_8000_0000)))
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* sv/scd_if.sv */
`timescale 1ns / 1ps

interface scd_in_if;
    import scd_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface scd_out_if;
    import scd_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

/* sv/scd_isqrt.sv */
`timescale 1ns / 1ps

module scd_isqrt
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [scd_pkg::DIST2_W-1:0]  rad,
    output logic [scd_pkg::DIST_W-1:0]   root
);
    import scd_pkg::*;

    localparam int REM_W = DIST2_W + 2;

    logic [REM_W-1:0]  rem_reg  [SQRT_STEPS-1];
    logic [DIST_W-1:0] root_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        localparam int B = SQRT_STEPS - 1 - k;
        logic [REM_W-1:0]  rem_in;
        logic [DIST_W-1:0] root_in;
        logic [REM_W-1:0]  trial;
        logic              take;

        if (k == 0)
        begin : g_first
            assign rem_in  = REM_W'(rad);
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b), bits never overlap
        assign trial = (REM_W'(root_in) << (B + 1)) | (REM_W'(1) << (2 * B));
        assign take  = rem_in >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= take ? (root_in | (DIST_W'(1) << B)) : root_in;
            end
        end

        if (k < SQRT_STEPS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? (rem_in - trial) : rem_in;
                end
            end
        end
    end

    assign root = root_reg[SQRT_STEPS-1];

endmodule

/* sv/scd_ndiv.sv */
`timescale 1ns / 1ps

module scd_ndiv
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [scd_pkg::NUM_W-1:0]   num [3],
    input  logic [scd_pkg::DIST_W-1:0]  den,
    output logic [scd_pkg::QUO_W-1:0]   quo [3]
);
    import scd_pkg::*;

    localparam int CMP_W = NUM_W + 2;

    logic [DIST_W-1:0] den_reg [DIV_STEPS-1];
    logic [NUM_W-1:0]  rem_reg [3][DIV_STEPS-1];
    logic [QUO_W-1:0]  quo_reg [3][DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        localparam int J = DIV_STEPS - 1 - k;
        logic [DIST_W-1:0] den_in;
        logic [CMP_W-1:0]  dsh;

        if (k == 0)
        begin : g_den_first
            assign den_in = den;
        end
        else
        begin : g_den_next
            assign den_in = den_reg[k-1];
        end

        assign dsh = CMP_W'(den_in) << J;

        if (k < DIV_STEPS - 1)
        begin : g_den
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[k] <= den_in;
                end
            end
        end

        for (genvar i = 0; i < 3; i++)
        begin : g_lane
            logic [NUM_W-1:0] rem_in;
            logic [QUO_W-1:0] quo_in;
            logic             take;

            if (k == 0)
            begin : g_first
                assign rem_in = num[i];
                assign quo_in = '0;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[i][k-1];
                assign quo_in = quo_reg[i][k-1];
            end

            assign take = CMP_W'(rem_in) >= dsh;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    quo_reg[i][k] <= take ? (quo_in | (QUO_W'(1) << J)) : quo_in;
                end
            end

            if (k < DIV_STEPS - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[i][k] <= take ? (rem_in - dsh[NUM_W-1:0]) : rem_in;
                    end
                end
            end
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_out
        assign quo[i] = quo_reg[i][DIV_STEPS-1];
    end

endmodule

/* sv/sphere_contact_detect.sv */
`timescale 1ns / 1ps

// Sphere pair contact test and contact geometry. One pair is taken every
// cycle; its result passes in order through an input register, three
// stages for the differences, squares and the exact contact compare, a
// 35-stage square root (one distance bit per stage), a 31-stage divider
// that forms the three normal components side by side (one quotient bit per
// stage), three stages for the contact point offset and the output register.
// The whole pipeline advances together: while hits.ready is low and a result
// waits, nothing moves and pairs.ready is low. Pairs not in contact return
// all fields zero; coincident centres give a zero normal.

module sphere_contact_detect
(
    input  logic      clk,
    input  logic      rst_n,
    scd_in_if.sink    pairs,
    scd_out_if.source hits
);
    import scd_pkg::*;

    typedef struct packed {
        logic                       contact;
        logic [2:0]                 neg;
        logic [2:0][MAG_W-1:0]      mag;
        logic [2:0][31:0]           b;
        logic [30:0]                ra;
        logic [30:0]                rb;
    } sq_pay_t;

    typedef struct packed {
        logic                       contact;
        logic [2:0]                 neg;
        logic [2:0][31:0]           b;
        logic signed [K2_W-1:0]     k2;
        logic [31:0]                ov;
        logic [31:0]                gap;
        logic                       dist_zero;
    } dv_pay_t;

    logic en;

    // input register
    logic     v0_reg;
    in_item_t in0_reg;

    // differences
    logic                  v1_reg;
    logic [2:0][MAG_W-1:0] mag1_reg;
    logic [2:0]            neg1_reg;
    logic [S2_W-1:0]       s2_1_reg;
    logic [2:0][31:0]      b1_reg;
    logic [30:0]           ra1_reg;
    logic [30:0]           rb1_reg;

    // squares
    logic                      v2_reg;
    logic [2:0][2*MAG_W-1:0]   sq2_reg;
    logic [DIST2_W-1:0]        s2sq2_reg;
    logic [2:0][MAG_W-1:0]     mag2_reg;
    logic [2:0]                neg2_reg;
    logic [2:0][31:0]          b2_reg;
    logic [30:0]               ra2_reg;
    logic [30:0]               rb2_reg;

    // squared distance
    logic                  v3_reg;
    logic [DIST2_W-1:0]    dist2_3_reg;
    logic [DIST2_W-1:0]    s2sq3_reg;
    logic [2:0][MAG_W-1:0] mag3_reg;
    logic [2:0]            neg3_reg;
    logic [2:0][31:0]      b3_reg;
    logic [30:0]           ra3_reg;
    logic [30:0]           rb3_reg;
    logic                  contact3;

    logic    sqv_reg [SQRT_STEPS];
    sq_pay_t sqp_reg [SQRT_STEPS];
    logic    dvv_reg [DIV_STEPS];
    dv_pay_t dvp_reg [DIV_STEPS];

    logic [DIST_W-1:0] root_dist;
    logic [NUM_W-1:0]  num_a [3];
    logic [QUO_W-1:0]  quo [3];
    dv_pay_t           pay_a;
    sq_pay_t           sq_last;

    // clamped normal
    logic                     vB_reg;
    logic [2:0][31:0]         nB_reg;
    logic [2:0][QUO_W-1:0]    nmB_reg;
    dv_pay_t                  pB_reg;

    // offset partial products
    logic                     vC_reg;
    logic [2:0][PP_W-1:0]     plo_reg;
    logic [2:0][PP_W-1:0]     phi_reg;
    logic [2:0]               negC_reg;
    logic [2:0][31:0]         nC_reg;
    dv_pay_t                  pC_reg;

    // offset magnitude
    logic                     vD_reg;
    logic [2:0][OFFM_W-1:0]   offm_reg;
    logic [2:0]               negD_reg;
    logic [2:0][31:0]         nD_reg;
    dv_pay_t                  pD_reg;

    // output register
    logic      vE_reg;
    out_item_t out_reg;

    logic [2:0][31:0] touch_e;

    assign en          = !vE_reg || hits.ready;
    assign pairs.ready = en;
    assign hits.valid  = vE_reg;
    assign hits.item   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                sqv_reg[k] <= 1'b0;
            end
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dvv_reg[k] <= 1'b0;
            end
            vB_reg <= 1'b0;
            vC_reg <= 1'b0;
            vD_reg <= 1'b0;
            vE_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg     <= pairs.valid;
            v1_reg     <= v0_reg;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            sqv_reg[0] <= v3_reg;
            for (int k = 1; k < SQRT_STEPS; k++)
            begin
                sqv_reg[k] <= sqv_reg[k-1];
            end
            dvv_reg[0] <= sqv_reg[SQRT_STEPS-1];
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                dvv_reg[k] <= dvv_reg[k-1];
            end
            vB_reg <= dvv_reg[DIV_STEPS-1];
            vC_reg <= vB_reg;
            vD_reg <= vC_reg;
            vE_reg <= vD_reg;
        end
    end

    // front end: differences, squares, exact contact compare
    always_ff @(posedge clk)
    begin
        logic signed [MAG_W-1:0] d [3];
        logic [31:0] av [3];
        logic [31:0] bv [3];
        if (en)
        begin
            in0_reg <= pairs.item;

            av[0] = in0_reg.a_pos_x;
            av[1] = in0_reg.a_pos_y;
            av[2] = in0_reg.a_pos_z;
            bv[0] = in0_reg.b_pos_x;
            bv[1] = in0_reg.b_pos_y;
            bv[2] = in0_reg.b_pos_z;
            for (int i = 0; i < 3; i++)
            begin
                d[i] = $signed({bv[i][31], bv[i]}) - $signed({av[i][31], av[i]});
                mag1_reg[i] <= d[i][MAG_W-1] ? MAG_W'(-d[i]) : MAG_W'(d[i]);
                neg1_reg[i] <= d[i][MAG_W-1];
                b1_reg[i]   <= bv[i];
            end
            s2_1_reg <= {2'b00, in0_reg.a_radius, 1'b0} + S2_W'(in0_reg.a_reach)
                      + {2'b00, in0_reg.b_radius, 1'b0} + S2_W'(in0_reg.b_reach);
            ra1_reg  <= in0_reg.a_radius;
            rb1_reg  <= in0_reg.b_radius;

            for (int i = 0; i < 3; i++)
            begin
                sq2_reg[i] <= (2*MAG_W)'(mag1_reg[i]) * (2*MAG_W)'(mag1_reg[i]);
            end
            s2sq2_reg <= DIST2_W'(s2_1_reg) * DIST2_W'(s2_1_reg);
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            b2_reg    <= b1_reg;
            ra2_reg   <= ra1_reg;
            rb2_reg   <= rb1_reg;

            dist2_3_reg <= DIST2_W'(sq2_reg[0]) + DIST2_W'(sq2_reg[1])
                         + DIST2_W'(sq2_reg[2]);
            s2sq3_reg   <= s2sq2_reg;
            mag3_reg    <= mag2_reg;
            neg3_reg    <= neg2_reg;
            b3_reg      <= b2_reg;
            ra3_reg     <= ra2_reg;
            rb3_reg     <= rb2_reg;
        end
    end

    assign contact3 = {dist2_3_reg, 2'b00} < {2'b00, s2sq3_reg};

    scd_isqrt u_isqrt
    (
        .clk  (clk),
        .en   (en),
        .rad  (dist2_3_reg),
        .root (root_dist)
    );

    // payload alongside the root and the divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqp_reg[0] <= '{contact: contact3, neg: neg3_reg, mag: mag3_reg,
                            b: b3_reg, ra: ra3_reg, rb: rb3_reg};
            for (int k = 1; k < SQRT_STEPS; k++)
            begin
                sqp_reg[k] <= sqp_reg[k-1];
            end
            dvp_reg[0] <= pay_a;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                dvp_reg[k] <= dvp_reg[k-1];
            end
        end
    end

    assign sq_last = sqp_reg[SQRT_STEPS-1];

    always_comb
    begin
        logic signed [K2_W-1:0] ovw;
        for (int i = 0; i < 3; i++)
        begin
            // rounded quotient: (mag * 2^30 + dist / 2) / dist
            num_a[i] = NUM_W'({sq_last.mag[i], 30'd0}) + NUM_W'(root_dist >> 1);
        end
        ovw = $signed(K2_W'(sq_last.ra)) + $signed(K2_W'(sq_last.rb))
            - $signed(K2_W'(root_dist));
        pay_a.contact   = sq_last.contact;
        pay_a.neg       = sq_last.neg;
        pay_a.b         = sq_last.b;
        pay_a.k2        = $signed(K2_W'(sq_last.rb)) - $signed(K2_W'(sq_last.ra))
                        + $signed(K2_W'(root_dist));
        pay_a.ov        = sat32({ovw[K2_W-1], ovw});
        pay_a.gap       = (root_dist[DIST_W-1:32] != '0) ? 32'hFFFF_FFFF : root_dist[31:0];
        pay_a.dist_zero = root_dist == '0;
    end

    scd_ndiv u_ndiv
    (
        .clk (clk),
        .en  (en),
        .num (num_a),
        .den (root_dist),
        .quo (quo)
    );

    // back end: clamp normal, offset product, contact point
    always_ff @(posedge clk)
    begin
        logic [QUO_W-1:0]  qs;
        logic [KMAG_W-1:0] kmag;
        logic [PSUM_W-1:0] psum;
        logic [WIDE_W-1:0] tw;
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                qs = (quo[i] > NORM_ONE) ? NORM_ONE : quo[i];
                if (dvp_reg[DIV_STEPS-1].dist_zero)
                begin
                    qs = '0;
                end
                nmB_reg[i] <= qs;
                nB_reg[i]  <= dvp_reg[DIV_STEPS-1].neg[i] ? -{1'b0, qs} : {1'b0, qs};
            end
            pB_reg <= dvp_reg[DIV_STEPS-1];

            kmag = pB_reg.k2[K2_W-1] ? KMAG_W'(-pB_reg.k2) : KMAG_W'(pB_reg.k2);
            for (int i = 0; i < 3; i++)
            begin
                plo_reg[i]  <= PP_W'(kmag[KHALF_W-1:0]) * PP_W'(nmB_reg[i]);
                phi_reg[i]  <= PP_W'(kmag[KMAG_W-1:KHALF_W]) * PP_W'(nmB_reg[i]);
                negC_reg[i] <= pB_reg.k2[K2_W-1] ^ nB_reg[i][31];
            end
            nC_reg <= nB_reg;
            pC_reg <= pB_reg;

            for (int i = 0; i < 3; i++)
            begin
                psum = (PSUM_W'(phi_reg[i]) << KHALF_W) + PSUM_W'(plo_reg[i]) + ROUND_HALF;
                offm_reg[i] <= psum[PSUM_W-1:31];
            end
            negD_reg <= negC_reg;
            nD_reg   <= nC_reg;
            pD_reg   <= pC_reg;

            out_reg <= '0;
            if (pD_reg.contact)
            begin
                out_reg.in_contact   <= 1'b1;
                out_reg.normal_x     <= nD_reg[0];
                out_reg.normal_y     <= nD_reg[1];
                out_reg.normal_z     <= nD_reg[2];
                out_reg.gap_distance <= pD_reg.gap;
                out_reg.overlap      <= pD_reg.ov;
                out_reg.touch_x      <= touch_e[0];
                out_reg.touch_y      <= touch_e[1];
                out_reg.touch_z      <= touch_e[2];
            end
        end
    end

    // touch = b - signed offset, folded into one add or subtract
    always_comb
    begin
        logic signed [WIDE_W-1:0] bw;
        logic signed [WIDE_W-1:0] ow;
        for (int i = 0; i < 3; i++)
        begin
            bw = $signed({{(WIDE_W-32){pD_reg.b[i][31]}}, pD_reg.b[i]});
            ow = $signed(WIDE_W'(offm_reg[i]));
            touch_e[i] = sat32(negD_reg[i] ? (bw + ow) : (bw - ow));
        end
    end

    a_no_contact_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (hits.valid && !hits.item.in_contact) |->
            (hits.item.normal_x == 0 && hits.item.normal_y == 0 &&
             hits.item.normal_z == 0 && hits.item.gap_distance == 0 &&
             hits.item.overlap == 0 && hits.item.touch_x == 0 &&
             hits.item.touch_y == 0 && hits.item.touch_z == 0))
        else $error("non-contact result carries geometry");

    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        hits.valid |->
            (hits.item.normal_x <= 32'sh4000_0000 && hits.item.normal_x >= -32'sh4000_0000 &&
             hits.item.normal_y <= 32'sh4000_0000 && hits.item.normal_y >= -32'sh4000_0000 &&
             hits.item.normal_z <= 32'sh4000_0000 && hits.item.normal_z >= -32'sh4000_0000))
        else $error("normal component out of unit range");

    a_coincident_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (hits.valid && hits.item.gap_distance == 0) |->
            (hits.item.normal_x == 0 && hits.item.normal_y == 0 &&
             hits.item.normal_z == 0))
        else $error("zero distance with nonzero normal");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (pairs.valid && pairs.ready) |=> v0_reg)
        else $error("accepted item not captured");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (vE_reg && !hits.ready) |=> ($stable(vD_reg) && $stable(dvv_reg[0])))
        else $error("pipeline moved during stall");

endmodule

/* tb/tb_sphere_contact_detect.sv */
`timescale 1ns / 1ps

module tb_sphere_contact_detect;
    import scd_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    scd_in_if  pairs ();
    scd_out_if hits ();

    sphere_contact_detect dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .pairs (pairs.sink),
        .hits  (hits.source)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    out_item_t hit_queue[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        recv_hold = 1'b0;
    bit        stim_done = 1'b0;

    typedef struct {
        in_item_t  pair;
        bit        known;
        out_item_t hit;
    } vec_t;

    vec_t vecs[$];

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF)
            return 32'h7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // floor square root, one bit per pass
    function automatic logic [63:0] isqrt(input logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = 0;
        for (int bit_i = 34; bit_i >= 0; bit_i--)
        begin
            c = r | (64'd1 << bit_i);
            sq = c * c;
            if (sq <= n)
                r = c;
        end
        return r;
    endfunction

    function automatic out_item_t contact_of(input in_item_t p);
        out_item_t          h;
        logic signed [63:0] a[3], b[3], d[3], nrm[3];
        logic [127:0]       dist2, lhs, rhs, prod;
        logic [63:0]        s2, cdist, q, offm;
        logic signed [63:0] ov, k2, off;
        h = '0;
        a[0] = p.a_pos_x; a[1] = p.a_pos_y; a[2] = p.a_pos_z;
        b[0] = p.b_pos_x; b[1] = p.b_pos_y; b[2] = p.b_pos_z;
        dist2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = b[i] - a[i];
            dist2 += 128'(mag64(d[i])) * 128'(mag64(d[i]));
        end
        s2 = 2 * 64'(p.a_radius) + 64'(p.a_reach) + 2 * 64'(p.b_radius) + 64'(p.b_reach);
        lhs = dist2 << 2;
        rhs = 128'(s2) * 128'(s2);
        if (!(lhs < rhs))
            return h;
        cdist = isqrt(dist2);
        for (int i = 0; i < 3; i++)
        begin
            nrm[i] = 0;
            if (cdist != 0)
            begin
                q = ((mag64(d[i]) << 30) + cdist / 2) / cdist;
                if (q > 64'd1073741824)
                    q = 64'd1073741824;
                nrm[i] = d[i] < 0 ? -$signed(q) : $signed(q);
            end
        end
        ov = $signed(64'(p.a_radius) + 64'(p.b_radius)) - $signed(cdist);
        k2 = $signed(64'(p.b_radius)) - $signed(64'(p.a_radius)) + $signed(cdist);
        h.in_contact = 1'b1;
        h.normal_x = nrm[0][31:0];
        h.normal_y = nrm[1][31:0];
        h.normal_z = nrm[2][31:0];
        h.gap_distance = cdist > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : cdist[31:0];
        h.overlap = clip32(ov);
        for (int i = 0; i < 3; i++)
        begin
            prod = 128'(mag64(k2)) * 128'(mag64(nrm[i])) + 128'd1073741824;
            offm = 64'(prod >> 31);
            off = ((k2 < 0) != (nrm[i] < 0)) ? -$signed(offm) : $signed(offm);
            if (i == 0) h.touch_x = clip32(b[i] - off);
            if (i == 1) h.touch_y = clip32(b[i] - off);
            if (i == 2) h.touch_z = clip32(b[i] - off);
        end
        return h;
    endfunction

    function automatic logic [31:0] rnd_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($urandom_range(0, 2000000)) - 32'd1000000;
            default: return 32'($urandom_range(0, 60000)) - 32'd30000;
        endcase
    endfunction

    function automatic logic [30:0] rnd_len(input int mode);
        case (mode)
            0: return 31'($urandom());
            1: return 31'($urandom_range(0, 600000));
            default: return 31'($urandom_range(0, 30000));
        endcase
    endfunction

    function automatic in_item_t rnd_pair();
        in_item_t p;
        int       cm, lm;
        cm = $urandom_range(0, 9) < 1 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
        lm = $urandom_range(0, 9) < 1 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
        p.a_pos_x = rnd_coord(cm); p.a_pos_y = rnd_coord(cm); p.a_pos_z = rnd_coord(cm);
        if ($urandom_range(0, 3) == 0)
        begin
            p.b_pos_x = rnd_coord(cm); p.b_pos_y = rnd_coord(cm); p.b_pos_z = rnd_coord(cm);
        end
        else
        begin
            // near neighbour so most pairs are in contact
            p.b_pos_x = p.a_pos_x + rnd_coord(2);
            p.b_pos_y = p.a_pos_y + rnd_coord(2);
            p.b_pos_z = p.a_pos_z + rnd_coord(2);
        end
        p.a_radius = rnd_len(lm); p.b_radius = rnd_len(lm);
        p.a_reach = rnd_len(lm); p.b_reach = rnd_len(lm);
        return p;
    endfunction

    task automatic add_vec(input in_item_t p, input bit known, input out_item_t h);
        vec_t v;
        v.pair = p;
        v.known = known;
        v.hit = h;
        vecs.push_back(v);
    endtask

    // valid stays high between back to back items and drops only while idling
    task automatic send_pair(input in_item_t p);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pairs.valid <= 1'b0;
            @(negedge clk);
        end
        pairs.valid <= 1'b1;
        pairs.item <= p;
        @(posedge clk);
        while (!pairs.ready)
            @(posedge clk);
        hit_queue.push_back(contact_of(p));
        @(negedge clk);
    endtask

    task automatic build_directed();
        in_item_t  p;
        out_item_t z;
        z = '0;
        // all zero: coincident centres, zero radii, not in contact
        p = '0;
        add_vec(p, 1'b1, z);
        // coincident centres in contact: zero normal, zero distance
        p.a_radius = 31'h10000; p.b_radius = 31'h10000;
        z.in_contact = 1'b1; z.overlap = 32'h20000;
        z.touch_x = 0; z.touch_y = 0; z.touch_z = 0;
        add_vec(p, 1'b1, z);
        // far apart, no contact
        p = '0;
        p.a_pos_x = 32'h8000_0000; p.b_pos_x = 32'h7FFF_FFFF;
        p.a_radius = 31'h10000; p.b_radius = 31'h10000;
        add_vec(p, 1'b1, '0);
        // maximum radii and reaches at the extremes
        p.a_pos_y = 32'h8000_0000; p.a_pos_z = 32'h8000_0000;
        p.b_pos_y = 32'h7FFF_FFFF; p.b_pos_z = 32'h7FFF_FFFF;
        p.a_radius = '1; p.b_radius = '1; p.a_reach = '1; p.b_reach = '1;
        add_vec(p, 1'b0, '0);
        p.b_radius = 0; add_vec(p, 1'b0, '0);
        p.a_radius = 0; p.b_radius = '1; add_vec(p, 1'b0, '0);
        // single-axis directions: negative x, positive y, negative z
        p = '0;
        p.b_pos_x = -32'sh30000; p.a_radius = 31'h20000; p.b_radius = 31'h20000;
        add_vec(p, 1'b0, '0);
        p.b_pos_x = 0; p.b_pos_y = 32'h30000; add_vec(p, 1'b0, '0);
        p.b_pos_y = 0; p.b_pos_z = -32'sh30000; add_vec(p, 1'b0, '0);
        // contact only through the reach; exact boundary and one inside
        p = '0;
        p.b_pos_x = 32'h40000; p.a_radius = 31'h10000; p.b_radius = 31'h10000;
        p.a_reach = 31'h20000; p.b_reach = 31'h20000;
        add_vec(p, 1'b0, '0);
        p.b_reach = 31'h20001; add_vec(p, 1'b0, '0);
        // tiny distance, huge radius offset
        p = '0;
        p.b_pos_z = 32'd1; p.b_radius = '1; p.a_reach = 31'd4;
        add_vec(p, 1'b0, '0);
        p.a_pos_x = 32'h7FFF_FFFF; p.b_pos_x = 32'h8000_0000; p.a_reach = '1;
        add_vec(p, 1'b0, '0);
        for (int i = 0; i < 8; i++)
            add_vec(rnd_pair(), 1'b0, '0);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
            send_pair(rnd_pair());
    endtask

    initial
    begin
        pairs.valid = 1'b0;
        pairs.item = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        build_directed();
        foreach (vecs[i])
        begin
            if (vecs[i].known && contact_of(vecs[i].pair) != vecs[i].hit)
            begin
                $error("directed row %0d: typed result disagrees with predictor", i);
                errors++;
            end
            send_pair(vecs[i].pair);
        end
        send_idle_pct = 23; recv_idle_pct = 86;
        run_random(600);
        send_idle_pct = 86; recv_idle_pct = 23;
        run_random(400);
        send_idle_pct = 0; recv_idle_pct = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (300) @(negedge clk);
                recv_hold = 1'b0;
            end
            run_random(500);
        join
        run_random(400);
        pairs.valid <= 1'b0;
        while (hit_queue.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        stim_done = 1'b1;
    end

    initial
    begin
        hits.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            hits.ready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && hits.valid && hits.ready)
        begin
            out_item_t want;
            out_item_t got;
            got = hits.item;
            if (hit_queue.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                want = hit_queue.pop_front();
                if (got.in_contact != want.in_contact)
                begin
                    $error("in_contact: expected %0d got %0d", want.in_contact, got.in_contact);
                    errors++;
                end
                if (got.normal_x != want.normal_x)
                begin
                    $error("normal_x: expected %0d got %0d", want.normal_x, got.normal_x);
                    errors++;
                end
                if (got.normal_y != want.normal_y)
                begin
                    $error("normal_y: expected %0d got %0d", want.normal_y, got.normal_y);
                    errors++;
                end
                if (got.normal_z != want.normal_z)
                begin
                    $error("normal_z: expected %0d got %0d", want.normal_z, got.normal_z);
                    errors++;
                end
                if (got.gap_distance != want.gap_distance)
                begin
                    $error("gap_distance: expected %0d got %0d",
                           want.gap_distance, got.gap_distance);
                    errors++;
                end
                if (got.overlap != want.overlap)
                begin
                    $error("overlap: expected %0d got %0d", want.overlap, got.overlap);
                    errors++;
                end
                if (got.touch_x != want.touch_x)
                begin
                    $error("touch_x: expected %0d got %0d", want.touch_x, got.touch_x);
                    errors++;
                end
                if (got.touch_y != want.touch_y)
                begin
                    $error("touch_y: expected %0d got %0d", want.touch_y, got.touch_y);
                    errors++;
                end
                if (got.touch_z != want.touch_z)
                begin
                    $error("touch_z: expected %0d got %0d", want.touch_z, got.touch_z);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #400000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
sv/scd_pkg.sv
sv/scd_if.sv
sv/scd_isqrt.sv
sv/scd_ndiv.sv
sv/sphere_contact_detect.sv
tb/tb_sphere_contact_detect.sv
